// ----- rtl/assert_macros.svh -----
// Assertion helpers; the using module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SRM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define SRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/srm_pkg.sv -----
package srm_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [31:0] word_t;
    typedef logic [3:0]  word_idx_t;
    typedef logic [3:0]  count_t;

    typedef enum logic [2:0] {
        ACT_START_WR = 3'd0,
        ACT_START_RD = 3'd1,
        ACT_WR_BYTE  = 3'd2,
        ACT_RD_BYTE  = 3'd3,
        ACT_STOP     = 3'd4,
        ACT_LOAD     = 3'd5
    } action_t;

    localparam int NUM_WORDS = 13;
    localparam int NUM_STAGE = 12;

    localparam byte_t  ID_VALUE      = 8'h51;
    localparam byte_t  ADDR_ID       = 8'h00;
    localparam byte_t  ADDR_GYRO     = 8'h10;
    localparam byte_t  ADDR_QUAT     = 8'h30;
    localparam byte_t  ADDR_RATE     = 8'h40;
    localparam byte_t  ADDR_TORQUE   = 8'h50;
    localparam byte_t  ADDR_ACCEL    = 8'h70;
    localparam byte_t  ADDR_COMBO    = 8'h7C;
    localparam byte_t  LEN_WIN3      = 8'd12;
    localparam byte_t  LEN_QUAT      = 8'd16;

    localparam word_idx_t WORD_QUAT  = 4'd0;
    localparam word_idx_t WORD_RATE  = 4'd4;
    localparam word_idx_t WORD_ACCEL = 4'd7;
    localparam word_idx_t WORD_GYRO  = 4'd10;
    localparam word_idx_t WORD_LAST  = 4'(NUM_WORDS - 1);

    localparam count_t COUNT_FULL    = 4'(NUM_STAGE + 1);

    localparam word_t LIVE_RESET_W0  = 32'h3F80_0000;

endpackage

// ----- rtl/srm_if.sv -----
interface srm_item_if import srm_pkg::*;;
    logic      valid;
    logic      ready;
    logic [2:0] action;
    byte_t     byte_in;
    logic [3:0] sample_index;
    word_t     sample_word;

    modport source (output valid, output action, output byte_in, output sample_index,
                    output sample_word, input ready);
    modport sink   (input valid, input action, input byte_in, input sample_index,
                    input sample_word, output ready);
endinterface

interface srm_result_if import srm_pkg::*;;
    logic  valid;
    logic  ready;
    byte_t read_data;
    logic  torque_update;
    word_t torque_x;
    word_t torque_y;
    word_t torque_z;

    modport source (output valid, output read_data, output torque_update,
                    output torque_x, output torque_y, output torque_z, input ready);
    modport sink   (input valid, input read_data, input torque_update,
                    input torque_x, input torque_y, input torque_z, output ready);
endinterface

// ----- rtl/sensor_register_map_i2c_target_core.sv -----
// Register front end of a motion sensor target: each item is one bus event (start write,
// start read, write byte, read byte, stop) or one sample load from the plant, and gives
// exactly one result carrying the read byte, the torque commit flag and the held torque
// words. State is updated at the input transfer and the result lands in a single
// output register, so a new item is taken in every cycle in which that register is
// empty or being drained. Start read copies all thirteen live words into the snapshot
// in that same cycle. No clearing pass is needed after reset.
`include "assert_macros.svh"

module sensor_register_map_i2c_target_core import srm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    srm_item_if.sink     item,
    srm_result_if.source result
);

    byte_t  pointer_reg, pointer_next;
    count_t count_reg, count_next;
    byte_t  stage_reg [NUM_STAGE];
    word_t  held_reg  [3];
    word_t  live_reg  [NUM_WORDS];
    word_t  snap_reg  [NUM_WORDS];

    logic   out_valid_reg;
    byte_t  rd_reg, rd_next;
    logic   upd_reg, upd_next;

    logic      accept;
    action_t   act;
    logic      stage_we;
    logic      commit;
    logic      snap_take;
    logic      live_we;

    // read map decode
    byte_t     off8;
    logic      map_hit;
    word_idx_t map_word;
    logic [1:0] map_lane;
    byte_t     map_byte;

    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign act        = action_t'(item.action);

    always_comb
    begin
        map_hit  = 1'b0;
        map_word = '0;
        map_lane = '0;
        off8     = '0;
        if ((pointer_reg - ADDR_GYRO) < LEN_WIN3)
        begin
            off8    = pointer_reg - ADDR_GYRO;
            map_hit = 1'b1;
            map_word = WORD_GYRO + {2'b00, off8[3:2]};
        end
        else if ((pointer_reg - ADDR_QUAT) < LEN_QUAT)
        begin
            off8    = pointer_reg - ADDR_QUAT;
            map_hit = 1'b1;
            map_word = WORD_QUAT + {2'b00, off8[3:2]};
        end
        else if ((pointer_reg - ADDR_RATE) < LEN_WIN3)
        begin
            off8    = pointer_reg - ADDR_RATE;
            map_hit = 1'b1;
            map_word = WORD_RATE + {2'b00, off8[3:2]};
        end
        else if ((pointer_reg - ADDR_ACCEL) < LEN_WIN3)
        begin
            off8    = pointer_reg - ADDR_ACCEL;
            map_hit = 1'b1;
            map_word = WORD_ACCEL + {2'b00, off8[3:2]};
        end
        else if ((pointer_reg - ADDR_COMBO) < LEN_WIN3)
        begin
            off8    = pointer_reg - ADDR_COMBO;
            map_hit = 1'b1;
            map_word = WORD_GYRO + {2'b00, off8[3:2]};
        end
        map_lane = off8[1:0];

        if (pointer_reg == ADDR_ID)
            map_byte = ID_VALUE;
        else if (map_hit && map_word <= WORD_LAST)
            map_byte = byte_t'(snap_reg[map_word] >> {map_lane, 3'b000});
        else
            map_byte = '0;
    end

    always_comb
    begin
        pointer_next = pointer_reg;
        count_next   = count_reg;
        rd_next      = '0;
        upd_next     = 1'b0;
        stage_we     = 1'b0;
        commit       = 1'b0;
        snap_take    = 1'b0;
        live_we      = 1'b0;
        unique case (act)
            ACT_START_WR:
                count_next = '0;
            ACT_START_RD:
            begin
                count_next = '0;
                snap_take  = 1'b1;
            end
            ACT_WR_BYTE:
            begin
                if (count_reg == '0)
                begin
                    pointer_next = item.byte_in;
                    count_next   = 4'd1;
                end
                else if (pointer_reg == ADDR_TORQUE && count_reg < COUNT_FULL)
                begin
                    stage_we   = 1'b1;
                    count_next = count_reg + 4'd1;
                end
            end
            ACT_RD_BYTE:
            begin
                rd_next      = map_byte;
                pointer_next = pointer_reg + 8'd1;
            end
            ACT_STOP:
            begin
                commit     = (pointer_reg == ADDR_TORQUE) && (count_reg == COUNT_FULL);
                upd_next   = commit;
                count_next = '0;
            end
            ACT_LOAD:
                live_we = (item.sample_index <= WORD_LAST);
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pointer_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_reg        <= '0;
            upd_reg       <= 1'b0;
            for (int i = 0; i < 3; i++)
                held_reg[i] <= '0;
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                live_reg[i] <= (i == 0) ? LIVE_RESET_W0 : '0;
                snap_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                pointer_reg   <= pointer_next;
                count_reg     <= count_next;
                rd_reg        <= rd_next;
                upd_reg       <= upd_next;
                out_valid_reg <= 1'b1;
                if (commit)
                begin
                    for (int i = 0; i < 3; i++)
                        held_reg[i] <= {stage_reg[4*i+3], stage_reg[4*i+2],
                                        stage_reg[4*i+1], stage_reg[4*i]};
                end
                if (snap_take)
                begin
                    for (int i = 0; i < NUM_WORDS; i++)
                        snap_reg[i] <= live_reg[i];
                end
                if (live_we)
                    live_reg[item.sample_index] <= item.sample_word;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // staging bytes are only read after being written in the same transaction
    always_ff @(posedge clk)
    begin
        if (accept && stage_we)
            stage_reg[count_reg - 4'd1] <= item.byte_in;
    end

    assign result.valid         = out_valid_reg;
    assign result.read_data     = rd_reg;
    assign result.torque_update = upd_reg;
    // held words only change on a transfer that also reloads the output register
    assign result.torque_x      = held_reg[0];
    assign result.torque_y      = held_reg[1];
    assign result.torque_z      = held_reg[2];

    `SRM_ASSERT_NEXT(a_accept_gives_result, accept, result.valid)
    `SRM_ASSERT_NEXT(a_commit_flagged, accept && commit, result.torque_update)
    `SRM_ASSERT_IMP(a_update_after_stop, result.valid && result.torque_update, count_reg == '0)
    `SRM_ASSERT_IMP(a_count_bounded, 1'b1, count_reg <= COUNT_FULL)

endmodule
